>>> rtl/core/scba_pkg.sv
// ----------------------------------------------------------------------------
// scba_pkg
// Shared types and codes for the size-class bitmap slot allocator.
// ----------------------------------------------------------------------------
package scba_pkg;

	localparam int ADDR_W    = 18;
	localparam int BYTES_W   = 16;
	localparam int CLASS_W   = 4;
	localparam int WORD_BITS = 64;
	localparam int BIT_W     = 6;

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	typedef enum logic [1:0] {
		ST_OK,
		ST_TOO_LARGE,
		ST_OUT_OF_PAGES,
		ST_BAD_FREE
	} status_t;

	typedef struct packed {
		logic                command;
		logic [BYTES_W-1:0]  request_bytes;
		logic [ADDR_W-1:0]   free_address;
	} request_t;

	typedef struct packed {
		status_t             status;
		logic [CLASS_W-1:0]  size_class;
		logic [ADDR_W-1:0]   slot_address;
	} result_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_A_CHECK,
		S_W_CK,
		S_W_RD,
		S_CLAIM,
		S_CLR,
		S_S_RD,
		S_S_CK,
		S_S_WR,
		S_F_CHK,
		S_F_RD,
		S_F_CK,
		S_F_RD2,
		S_F_BIT,
		S_ADDR
	} ctrl_state_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_PAGE_NEXT,
		OP_HIT,
		OP_CLAIM,
		OP_CLR,
		OP_WORD_NEXT,
		OP_FOUND,
		OP_SET,
		OP_FPAGE,
		OP_FSLOT,
		OP_CLEAR,
		OP_RES
	} dp_op_t;

	typedef struct packed {
		dp_op_t  op;
		status_t code;
	} dp_cmd_t;

	typedef struct packed {
		logic too_large;
		logic next_zero;
		logic pool_full;
		logic hit;
		logic last_page;
		logic clr_last;
		logic found;
		logic last_word;
		logic free_bad;
		logic slot_bad;
		logic bit_set;
	} dp_stat_t;

endpackage

>>> rtl/core/scba_ram.sv
// ----------------------------------------------------------------------------
// scba_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module scba_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

>>> rtl/core/scba_datapath.sv
// ----------------------------------------------------------------------------
// scba_datapath
// Page table, slot bitmaps, class decode, address decode and result register.
// ----------------------------------------------------------------------------
module scba_datapath #(
	parameter int NUM_PAGES    = 64,
	parameter int PAGE_BYTES   = 4096,
	parameter int HEADER_BYTES = 200,
	parameter int BITMAP_BITS  = 1024,
	parameter int NUM_CLASSES  = 11
) (
	input  logic               clk,
	input  logic               arst_n,
	input  scba_pkg::request_t request,
	input  scba_pkg::dp_cmd_t  cmd,
	output scba_pkg::dp_stat_t stat,
	output scba_pkg::result_t  result,
	output logic               done
);
	import scba_pkg::*;

	localparam int MAP_WORDS = (BITMAP_BITS + 63) / 64;
	localparam int WB        = MAP_WORDS > 1 ? $clog2(MAP_WORDS) : 1;
	localparam int SLOT_W    = WB + BIT_W;
	localparam int PI_W      = NUM_PAGES > 1 ? $clog2(NUM_PAGES) : 1;
	localparam int NP_W      = $clog2(NUM_PAGES + 1);
	localparam int CNT_W     = $clog2(BITMAP_BITS + 1);
	localparam int REM_W     = $clog2(PAGE_BYTES);
	localparam int AVAIL     = PAGE_BYTES > HEADER_BYTES ? PAGE_BYTES - HEADER_BYTES : 0;
	localparam int INFO_W    = CLASS_W + CNT_W;
	localparam int MAP_DEPTH = NUM_PAGES * (2 ** WB);

	function automatic logic [CNT_W-1:0] slots_of(input logic [CLASS_W-1:0] c);
		logic [31:0] n;
		n = 32'(AVAIL) >> (32'(c) + 32'd2);
		if (n > 32'(BITMAP_BITS)) n = 32'(BITMAP_BITS);
		return CNT_W'(n);
	endfunction

	logic [CLASS_W-1:0] cls_q;
	logic [PI_W-1:0]    page_q;
	logic [NP_W-1:0]    next_q;
	logic [WB-1:0]      word_q;
	logic [SLOT_W-1:0]  slot_q;
	logic [CNT_W-1:0]   free_q;
	logic [ADDR_W-1:0]  quo_q;
	logic [REM_W-1:0]   rem_q;
	result_t            result_q;
	logic               done_q;

	logic [INFO_W-1:0]    info_rd, info_wd;
	logic                 info_we;
	logic [WORD_BITS-1:0] map_rd, map_wd, bit_mask;
	logic                 map_we;
	logic [WB+PI_W-1:0]   map_addr;

	logic [CLASS_W-1:0]   info_cls;
	logic [CNT_W-1:0]     info_free;
	logic [CNT_W-1:0]     count_c;
	logic [BYTES_W-1:0]   bytes_m1;
	logic [4:0]           k_c;
	logic [CLASS_W-1:0]   cls_in;
	logic [BIT_W-1:0]     found_idx;
	logic                 found_c;
	logic [31:0]          fslot;
	logic [ADDR_W-1:0]    sum_addr;

	assign info_cls  = info_rd[INFO_W-1 -: CLASS_W];
	assign info_free = info_rd[CNT_W-1:0];
	assign count_c   = slots_of(cls_q);
	assign map_addr  = {page_q, word_q};
	assign bit_mask  = WORD_BITS'(1) << slot_q[BIT_W-1:0];

	scba_ram #(.WIDTH(INFO_W), .DEPTH(NUM_PAGES)) u_info_ram (
		.clk   (clk),
		.we    (info_we),
		.waddr (page_q),
		.wdata (info_wd),
		.raddr (page_q),
		.rdata (info_rd)
	);

	scba_ram #(.WIDTH(WORD_BITS), .DEPTH(MAP_DEPTH)) u_map_ram (
		.clk   (clk),
		.we    (map_we),
		.waddr (map_addr),
		.wdata (map_wd),
		.raddr (map_addr),
		.rdata (map_rd)
	);

	// class decode: smallest k with 2^k >= bytes
	always_comb begin
		bytes_m1 = request.request_bytes - BYTES_W'(1);
		k_c      = '0;
		if (request.request_bytes > BYTES_W'(1)) begin
			for (int i = 0; i < BYTES_W; i++) begin
				if (bytes_m1[i]) k_c = 5'(i + 1);
			end
		end
		cls_in = (k_c < 5'd2) ? '0 : CLASS_W'(k_c - 5'd2);
	end

	// lowest clear bit among slots below the page's slot count
	always_comb begin
		found_c   = 1'b0;
		found_idx = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (!map_rd[i] && (32'({word_q, BIT_W'(i)}) < 32'(count_c))) begin
				found_c   = 1'b1;
				found_idx = BIT_W'(i);
			end
		end
	end

	assign fslot    = (32'(rem_q) - 32'(HEADER_BYTES)) >> (32'(info_cls) + 32'd2);
	assign sum_addr = ADDR_W'(32'(page_q) * 32'(PAGE_BYTES)) + ADDR_W'(HEADER_BYTES)
		+ ADDR_W'(32'(slot_q) << (32'(cls_q) + 32'd2));

	always_comb begin
		stat.too_large = (32'(cls_q) >= 32'(NUM_CLASSES)) || (count_c == '0);
		stat.next_zero = (next_q == '0);
		stat.pool_full = (next_q == NP_W'(NUM_PAGES));
		stat.hit       = (info_cls == cls_q) && (info_free != '0);
		stat.last_page = ((NP_W'(page_q) + NP_W'(1)) == next_q);
		stat.clr_last  = (word_q == WB'(MAP_WORDS - 1));
		stat.found     = found_c;
		stat.last_word = (word_q == WB'((32'(count_c) - 32'd1) >> BIT_W));
		stat.free_bad  = (32'(quo_q) >= 32'(next_q)) || (32'(rem_q) < 32'(HEADER_BYTES));
		stat.slot_bad  = (fslot >= 32'(slots_of(info_cls)));
		stat.bit_set   = map_rd[slot_q[BIT_W-1:0]];
	end

	always_comb begin
		info_we = 1'b0;
		info_wd = {cls_q, count_c};
		map_we  = 1'b0;
		map_wd  = '0;
		case (cmd.op)
			OP_CLR: begin
				info_we = 1'b1;
				map_we  = 1'b1;
			end
			OP_SET: begin
				info_we = 1'b1;
				info_wd = {cls_q, free_q - CNT_W'(1)};
				map_we  = 1'b1;
				map_wd  = map_rd | bit_mask;
			end
			OP_CLEAR: begin
				info_we = 1'b1;
				info_wd = {cls_q, free_q + CNT_W'(1)};
				map_we  = 1'b1;
				map_wd  = map_rd & ~bit_mask;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cmd.op == OP_RES);
			if (cmd.op == OP_CLAIM) next_q <= next_q + NP_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				cls_q  <= cls_in;
				page_q <= '0;
				word_q <= '0;
				// page size is a power of two: page and offset split by bit fields
				quo_q  <= ADDR_W'(request.free_address >> REM_W);
				rem_q  <= request.free_address[REM_W-1:0];
			end
			OP_PAGE_NEXT: page_q <= page_q + PI_W'(1);
			OP_HIT: begin
				free_q <= info_free;
				word_q <= '0;
			end
			OP_CLAIM: begin
				page_q <= PI_W'(next_q);
				word_q <= '0;
			end
			OP_CLR: begin
				free_q <= count_c;
				word_q <= stat.clr_last ? '0 : word_q + WB'(1);
			end
			OP_WORD_NEXT: word_q <= word_q + WB'(1);
			OP_FOUND:     slot_q <= {word_q, found_idx};
			OP_FPAGE:     page_q <= quo_q[PI_W-1:0];
			OP_FSLOT: begin
				cls_q  <= info_cls;
				free_q <= info_free;
				slot_q <= fslot[SLOT_W-1:0];
				word_q <= fslot[SLOT_W-1:BIT_W];
			end
			OP_RES: begin
				result_q.status       <= cmd.code;
				result_q.size_class   <= (cmd.code == ST_BAD_FREE) ? '0 : cls_q;
				result_q.slot_address <= (cmd.code == ST_OK) ? sum_addr : '0;
			end
			default: ;
		endcase
	end

	assign result = result_q;
	assign done   = done_q;
endmodule

>>> rtl/core/scba_ctrl.sv
// ----------------------------------------------------------------------------
// scba_ctrl
// Sequencer for allocate and free requests.
// ----------------------------------------------------------------------------
module scba_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               command,
	input  scba_pkg::dp_stat_t stat,
	output scba_pkg::dp_cmd_t  cmd,
	output logic               busy
);
	import scba_pkg::*;

	ctrl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd.op   = OP_NONE;
		cmd.code = ST_OK;
		busy     = (state_q != S_IDLE);
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.op  = OP_LOAD;
					state_d = (command == CMD_FREE) ? S_F_CHK : S_A_CHECK;
				end
			end
			S_A_CHECK: begin
				if (stat.too_large) begin
					cmd.op   = OP_RES;
					cmd.code = ST_TOO_LARGE;
					state_d  = S_IDLE;
				end else if (stat.next_zero) begin
					state_d = S_CLAIM;
				end else begin
					state_d = S_W_CK;
				end
			end
			S_W_CK: begin
				if (stat.hit) begin
					cmd.op  = OP_HIT;
					state_d = S_S_RD;
				end else if (stat.last_page) begin
					if (stat.pool_full) begin
						cmd.op   = OP_RES;
						cmd.code = ST_OUT_OF_PAGES;
						state_d  = S_IDLE;
					end else begin
						state_d = S_CLAIM;
					end
				end else begin
					cmd.op  = OP_PAGE_NEXT;
					state_d = S_W_RD;
				end
			end
			S_W_RD: state_d = S_W_CK;
			S_CLAIM: begin
				cmd.op  = OP_CLAIM;
				state_d = S_CLR;
			end
			S_CLR: begin
				cmd.op = OP_CLR;
				if (stat.clr_last) state_d = S_S_RD;
			end
			S_S_RD: state_d = S_S_CK;
			S_S_CK: begin
				if (stat.found) begin
					cmd.op  = OP_FOUND;
					state_d = S_S_WR;
				end else if (stat.last_word) begin
					cmd.op   = OP_RES;
					cmd.code = ST_OUT_OF_PAGES;
					state_d  = S_IDLE;
				end else begin
					cmd.op  = OP_WORD_NEXT;
					state_d = S_S_RD;
				end
			end
			S_S_WR: begin
				cmd.op  = OP_SET;
				state_d = S_ADDR;
			end
			S_F_CHK: begin
				if (stat.free_bad) begin
					cmd.op   = OP_RES;
					cmd.code = ST_BAD_FREE;
					state_d  = S_IDLE;
				end else begin
					cmd.op  = OP_FPAGE;
					state_d = S_F_RD;
				end
			end
			S_F_RD: state_d = S_F_CK;
			S_F_CK: begin
				if (stat.slot_bad) begin
					cmd.op   = OP_RES;
					cmd.code = ST_BAD_FREE;
					state_d  = S_IDLE;
				end else begin
					cmd.op  = OP_FSLOT;
					state_d = S_F_RD2;
				end
			end
			S_F_RD2: state_d = S_F_BIT;
			S_F_BIT: begin
				if (!stat.bit_set) begin
					cmd.op   = OP_RES;
					cmd.code = ST_BAD_FREE;
					state_d  = S_IDLE;
				end else begin
					cmd.op  = OP_CLEAR;
					state_d = S_ADDR;
				end
			end
			S_ADDR: begin
				// slot address formed and latched with the ok status
				cmd.op   = OP_RES;
				cmd.code = ST_OK;
				state_d  = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end
endmodule

>>> rtl/core/size_class_bitmap_slot_allocator_top.sv
// ----------------------------------------------------------------------------
// size_class_bitmap_slot_allocator_top
// Power-of-two size-class slab allocator over a fixed page pool.
// ----------------------------------------------------------------------------
//
// channel   signals                      direction  handshake
// request   start, busy, request         in         taken when start & !busy
// result    done, result                 out        valid for the one cycle done is high
//
// handshake: busy covers the cycles after the request is taken; done rises in the
//   first cycle busy is low again
// allocate: ends at the class check when too large; otherwise a walk over the
//   claimed pages, a claim and bitmap clear of a fresh page when no claimed page
//   of the class has a free slot, then a bitmap word scan, bit set and address
// free: ends at the page check on a bad page or header hit, the slot check on a bad
//   slot, the bit check on a slot not allocated; the page size must be a power of two
// reset: page count cleared; unclaimed pages are never read, so no clear pass
// the receiver cannot stall: the result register holds each result until the next
//   result is latched
module size_class_bitmap_slot_allocator_top #(
	parameter int NUM_PAGES    = 64,
	parameter int PAGE_BYTES   = 4096,
	parameter int HEADER_BYTES = 200,
	parameter int BITMAP_BITS  = 1024,
	parameter int NUM_CLASSES  = 11
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  scba_pkg::request_t request,
	output logic               done,
	output scba_pkg::result_t  result
);
	import scba_pkg::*;

	// command and status between sequencer and datapath
	dp_cmd_t  dp_cmd;
	dp_stat_t dp_stat;

	scba_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.command (request.command),
		.stat    (dp_stat),
		.cmd     (dp_cmd),
		.busy    (busy)
	);

	// page table, bitmaps, address decode and result register
	scba_datapath #(
		.NUM_PAGES    (NUM_PAGES),
		.PAGE_BYTES   (PAGE_BYTES),
		.HEADER_BYTES (HEADER_BYTES),
		.BITMAP_BITS  (BITMAP_BITS),
		.NUM_CLASSES  (NUM_CLASSES)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.request (request),
		.cmd     (dp_cmd),
		.stat    (dp_stat),
		.result  (result),
		.done    (done)
	);
endmodule

>>> rtl/core/scba_checker.sv
// ----------------------------------------------------------------------------
// scba_checker
// Port-level checks on the allocator's request and result channels.
// ----------------------------------------------------------------------------
module scba_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic               done,
	input scba_pkg::result_t  result
);
	import scba_pkg::*;

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("result strobe held two cycles");

	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("request taken but not busy");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("result while still busy");

	a_bad_free_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status == ST_BAD_FREE)
		|-> (result.size_class == '0 && result.slot_address == '0))
		else $error("bad free reports nonzero fields");

	a_fail_addr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (result.status == ST_TOO_LARGE || result.status == ST_OUT_OF_PAGES))
		|-> (result.slot_address == '0)) else $error("failed allocate has an address");
endmodule

bind size_class_bitmap_slot_allocator_top scba_checker u_scba_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.result (result)
);
